FILE: sv/kmcs_pkg.sv
// ----------------------------------------------------------------------------
// kmcs_pkg
// Shared widths, defaults and the change record of the key matrix scanner.
// ----------------------------------------------------------------------------
package kmcs_pkg;

    localparam int KEY_W  = 6;   // sampled columns per row item
    localparam int ROW_W  = 2;   // row field of a scancode
    localparam int COL_W  = 3;   // column field of a scancode
    localparam int CODE_W = 8;

    localparam int DEFAULT_ROWS    = 4;
    localparam int DEFAULT_COLUMNS = 6;
    localparam int DEFAULT_QDEPTH  = 2;

    // One row sample that changed: the new levels and the columns that moved.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [KEY_W-1:0] levels;
        logic [KEY_W-1:0] change;
    } rec_t;

    typedef struct packed {
        logic push;
        logic full;
    } qwr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } qrd_t;

endpackage

FILE: sv/key_matrix_change_scanner_core.sv
// ----------------------------------------------------------------------------
// key_matrix_change_scanner_core
// Compares each sampled key row with its stored levels and reports every
// press or release as a scancode.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_axis   in   s_tvalid/s_tready  s_tdata[5:0] key_bits
//  m_axis   out  m_tvalid/m_tready  m_tdata[7:0] scancode, m_tlast last
//
//  A row item is taken whenever the change queue has room, also while the back
//  end is still busy with an earlier row; a row with no change produces nothing.
//  The back end emits one scancode per cycle while the output is not stalled, so
//  a row with k changed columns (at most six) gives k scancodes; that emitter sets the sustained rate.
//  Reset clears the row index and all stored row levels at once.
//  A stalled output holds its scancode while the front keeps taking rows until
//  the queue fills.
// ----------------------------------------------------------------------------
module key_matrix_change_scanner_core #(
    parameter int ROWS    = kmcs_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = kmcs_pkg::DEFAULT_COLUMNS,
    parameter int QDEPTH  = kmcs_pkg::DEFAULT_QDEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [5:0] key_bits, [7:6] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] scancode
    output logic       m_tlast
);
    import kmcs_pkg::*;

    rec_t fe_rec;
    rec_t q_rec;
    qwr_t q_wr;
    qrd_t q_rd;
    logic fe_push;
    logic be_pop;
    logic take;

    assign s_tready = !q_wr.full;
    assign take     = s_tvalid && s_tready;

    kmcs_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .key_bits (s_tdata[KEY_W-1:0]),
        .rec      (fe_rec),
        .push     (fe_push)
    );

    kmcs_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (fe_rec),
        .wr      (q_wr),
        .push    (fe_push),
        .rd_data (q_rec),
        .rd      (q_rd),
        .pop     (be_pop)
    );

    kmcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec      (q_rec),
        .rd       (q_rd),
        .pop      (be_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sv/kmcs_front.sv
// ----------------------------------------------------------------------------
// kmcs_front
// Accepts row samples, compares them with the stored levels of the row and
// hands changed rows to the queue.
// ----------------------------------------------------------------------------
module kmcs_front #(
    parameter int ROWS    = kmcs_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = kmcs_pkg::DEFAULT_COLUMNS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [kmcs_pkg::KEY_W-1:0] key_bits,
    output kmcs_pkg::rec_t          rec,
    output logic                    push
);
    import kmcs_pkg::*;

    localparam int EFF_COLS = (COLUMNS < KEY_W) ? COLUMNS : KEY_W;
    localparam logic [KEY_W-1:0] COL_MASK = KEY_W'((1 << EFF_COLS) - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [KEY_W-1:0] prior_reg [ROWS];
    logic [KEY_W-1:0] now_levels;
    logic [KEY_W-1:0] change;

    assign now_levels = key_bits & COL_MASK;
    assign change     = (prior_reg[row_reg] ^ now_levels) & COL_MASK;
    assign row_next   = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;

    assign rec.row    = row_reg;
    assign rec.levels = now_levels;
    assign rec.change = change;
    assign push       = take && (change != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                prior_reg[r] <= '0;
            end
        end
        else if (take)
        begin
            prior_reg[row_reg] <= now_levels;
            row_reg            <= row_next;
        end
    end

endmodule

FILE: sv/kmcs_queue.sv
// ----------------------------------------------------------------------------
// kmcs_queue
// Short queue of change records between the front and the back.
// ----------------------------------------------------------------------------
module kmcs_queue #(
    parameter int DEPTH = kmcs_pkg::DEFAULT_QDEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  kmcs_pkg::rec_t wr_data,
    output kmcs_pkg::qwr_t wr,
    input  logic           push,
    output kmcs_pkg::rec_t rd_data,
    output kmcs_pkg::qrd_t rd,
    input  logic           pop
);
    import kmcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign wr.full  = (count_reg == CNT_W'(DEPTH));
    assign wr.push  = do_push;
    assign rd.empty = (count_reg == '0);
    assign rd.pop   = do_pop;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_push  = push && !wr.full;
    assign do_pop   = pop && !rd.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/kmcs_back.sv
// ----------------------------------------------------------------------------
// kmcs_back
// Walks the changed columns of one record, lowest first, and drives one
// scancode per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module kmcs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmcs_pkg::rec_t                rec,
    input  kmcs_pkg::qrd_t                rd,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kmcs_pkg::CODE_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import kmcs_pkg::*;

    logic              work_valid_reg;
    logic [ROW_W-1:0]  work_row_reg;
    logic [KEY_W-1:0]  work_levels_reg;
    logic [KEY_W-1:0]  work_mask_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_last_reg;

    logic              advance;
    logic [COL_W-1:0]  col;
    logic [KEY_W-1:0]  mask_next;
    logic              final_col;
    logic              pressed;

    always_comb
    begin
        col = '0;
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            if (work_mask_reg[i])
            begin
                col = COL_W'(i);
            end
        end
    end

    assign mask_next = work_mask_reg & (work_mask_reg - 1'b1);
    assign final_col = (mask_next == '0);
    assign pressed   = work_levels_reg[col];
    assign advance   = work_valid_reg && (!out_valid_reg || m_tready);
    assign pop       = !rd.empty && (!work_valid_reg || (advance && final_col));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= {~pressed, 2'b00, col, work_row_reg};
            out_last_reg <= final_col;
        end
        if (pop)
        begin
            work_row_reg    <= rec.row;
            work_levels_reg <= rec.levels;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_mask_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (pop)
            begin
                work_valid_reg <= 1'b1;
                work_mask_reg  <= rec.change;
            end
            else if (advance)
            begin
                work_valid_reg <= !final_col;
                work_mask_reg  <= mask_next;
            end
        end
    end

endmodule

FILE: sv/kmcs_checker.sv
// ----------------------------------------------------------------------------
// kmcs_checker
// Port-level checks on the scancodes leaving the key matrix scanner.
// ----------------------------------------------------------------------------
module kmcs_checker #(
    parameter int ROWS    = kmcs_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = kmcs_pkg::DEFAULT_COLUMNS
) (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import kmcs_pkg::*;

    localparam int EFF_COLS = (COLUMNS < KEY_W) ? COLUMNS : KEY_W;

    // A held scancode must not change while the sink stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("scancode changed while stalled");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:5] == 2'b00)
        else $error("scancode bits 6:5 not zero");

    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> {1'b0, m_tdata[1:0]} < 3'(ROWS))
        else $error("scancode row out of range");

    a_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> {1'b0, m_tdata[4:2]} < 4'(EFF_COLS))
        else $error("scancode column out of range");

    // Nothing can come out of the first cycle after reset.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind key_matrix_change_scanner_core kmcs_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_kmcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
